@@ sv/cdu_pkg.sv @@
// Shared constants and helpers for the class-data ULEB128 decoder.
// Holds record kind codes, result packing widths and list selection.
// No dependencies.
package cdu_pkg;

	// Record kinds; a list section uses the code of the records it holds
	localparam logic [2:0] KIND_HEADER   = 3'd0;
	localparam logic [2:0] KIND_STATIC   = 3'd1;
	localparam logic [2:0] KIND_INSTANCE = 3'd2;
	localparam logic [2:0] KIND_DIRECT   = 3'd3;
	localparam logic [2:0] KIND_VIRTUAL  = 3'd4;

	// Value slots within a record or the header
	localparam logic [1:0] SLOT_DELTA = 2'd0;
	localparam logic [1:0] SLOT_FLAGS = 2'd1;
	localparam logic [1:0] SLOT_CODE  = 2'd2;
	localparam logic [1:0] SLOT_LAST_COUNT = 2'd3;

	// Last byte position of a 32-bit ULEB128 value
	localparam logic [2:0] POS_MAX = 3'd4;

	localparam int VALUE_W  = 32;
	localparam int BYTES_W  = 5;
	localparam int KIND_W   = 3;
	localparam int RAW_W    = 8 * VALUE_W + BYTES_W;
	localparam int TDATA_W  = ((RAW_W + 7) / 8) * 8;

	// First list after section 'from' with a nonzero count; header code if none
	function automatic logic [2:0] first_list(input logic [2:0] from,
						  input logic [3:0] nonzero);
		logic [2:0] sel;
		sel = KIND_HEADER;
		for (int i = 4; i >= 1; i--) begin
			if (3'(i) > from && nonzero[i - 1]) begin
				sel = 3'(i);
			end
		end
		return sel;
	endfunction

endpackage

@@ sv/class_data_uleb128_decoder_top.sv @@
// Class-data item decoder: ULEB128 byte stream in, header and member records out.
// Single module with an input register stage and a result register.
// Depends on cdu_pkg.

// One byte enters per cycle while s_axis_tready is high; a byte passes through
// the input register and is decoded once the result slot is free: it updates
// the value accumulator and list counters and, if it completes the header or a
// record, loads the result register. A result is therefore valid once the
// byte ending it leaves the input register, and the stream sustains one byte
// per clock while the result side takes each transaction as offered. Values
// longer than five bytes are cut at the fifth byte (only its low four bits
// count); member indexes wrap modulo 2^32; lists with a zero count are
// skipped, and tlast marks the result that ends an item.
module class_data_uleb128_decoder_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [7:0]                 s_axis_tdata,   // data_byte
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// static_count, instance_count, direct_count, virtual_count, member_index,
	// index_delta, member_flags, code_offset (32 each), record_bytes (5), zero pad
	output logic [cdu_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic [cdu_pkg::KIND_W-1:0]  m_axis_tuser,  // record_kind
	output logic                       m_axis_tlast    // last
);
	import cdu_pkg::*;

	// Input stage
	logic [7:0] byte_s1;
	logic       valid_s1;
	logic       advance;
	logic       accept_in;

	// Decoder state
	logic [2:0]         section_q;
	logic [1:0]         slot_q;
	logic [2:0]         pos_q;
	logic [VALUE_W-1:0] acc_q;
	logic [VALUE_W-1:0] counts_q [4];
	logic [VALUE_W-1:0] remaining_q;
	logic [VALUE_W-1:0] run_idx_q;
	logic [VALUE_W-1:0] delta_q;
	logic [VALUE_W-1:0] flags_q;
	logic [BYTES_W-1:0] bytes_q;

	// Next-state and result
	logic [2:0]         section_d;
	logic [1:0]         slot_d;
	logic [2:0]         pos_d;
	logic [VALUE_W-1:0] acc_d;
	logic [VALUE_W-1:0] counts_d [4];
	logic [VALUE_W-1:0] remaining_d;
	logic [VALUE_W-1:0] run_idx_d;
	logic [VALUE_W-1:0] delta_d;
	logic [VALUE_W-1:0] flags_d;
	logic [BYTES_W-1:0] bytes_d;

	logic [2:0]         pos;
	logic [VALUE_W-1:0] shifted;
	logic [VALUE_W-1:0] value;
	logic [BYTES_W-1:0] bytes_inc;
	logic [3:0]         nonzero;
	logic [2:0]         next_list;
	logic               emit;
	logic [2:0]         res_kind;
	logic [VALUE_W-1:0] res_index;
	logic [VALUE_W-1:0] res_delta;
	logic [VALUE_W-1:0] res_flags;
	logic [VALUE_W-1:0] res_code;
	logic               res_last;

	// Handshake: the input register moves on whenever the result slot is free
	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign accept_in     = s_axis_tvalid && s_axis_tready;

	// Hold the incoming byte in the input register until it is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Place the seven payload bits at the current byte position
	always_comb begin
		pos = (pos_q > POS_MAX) ? POS_MAX : pos_q;
		case (pos)
			3'd0:    shifted = {25'd0, byte_s1[6:0]};
			3'd1:    shifted = {18'd0, byte_s1[6:0], 7'd0};
			3'd2:    shifted = {11'd0, byte_s1[6:0], 14'd0};
			3'd3:    shifted = {4'd0, byte_s1[6:0], 21'd0};
			default: shifted = {byte_s1[3:0], 28'd0};
		endcase
		value     = acc_q | shifted;
		bytes_inc = bytes_q + 1'b1;
	end

	// Decode one byte
	always_comb begin
		section_d   = section_q;
		slot_d      = slot_q;
		pos_d       = 3'd0;
		acc_d       = '0;
		counts_d    = counts_q;
		remaining_d = remaining_q;
		run_idx_d   = run_idx_q;
		delta_d     = delta_q;
		flags_d     = flags_q;
		bytes_d     = bytes_inc;
		emit        = 1'b0;
		res_kind    = KIND_HEADER;
		res_index   = '0;
		res_delta   = '0;
		res_flags   = '0;
		res_code    = '0;
		res_last    = 1'b0;
		nonzero     = '0;
		next_list   = KIND_HEADER;

		if (byte_s1[7] && pos < POS_MAX) begin
			// Value continues: keep accumulating
			pos_d = pos + 3'd1;
			acc_d = value;
		end else if (section_q == KIND_HEADER || section_q > KIND_VIRTUAL) begin
			// Header count completes
			section_d        = KIND_HEADER;
			counts_d[slot_q] = value;
			if (slot_q != SLOT_LAST_COUNT) begin
				slot_d = slot_q + 2'd1;
			end else begin
				slot_d = SLOT_DELTA;
				for (int i = 0; i < 4; i++) begin
					nonzero[i] = (counts_d[i] != '0);
				end
				next_list   = first_list(KIND_HEADER, nonzero);
				section_d   = next_list;
				remaining_d = (next_list == KIND_HEADER) ? '0 :
				              counts_d[2'(next_list - 3'd1)];
				run_idx_d   = '0;
				emit        = 1'b1;
				res_kind    = KIND_HEADER;
				res_last    = (next_list == KIND_HEADER);
				bytes_d     = '0;
			end
		end else if (slot_q == SLOT_DELTA) begin
			// Index delta
			delta_d   = value;
			run_idx_d = run_idx_q + value;
			slot_d    = SLOT_FLAGS;
		end else if (slot_q == SLOT_FLAGS && section_q >= KIND_DIRECT) begin
			// Method flags; code offset still to come
			flags_d = value;
			slot_d  = SLOT_CODE;
		end else begin
			// Record completes
			if (slot_q == SLOT_FLAGS) begin
				flags_d   = value;
				res_flags = value;
			end else begin
				res_flags = flags_q;
				res_code  = value;
			end
			slot_d      = SLOT_DELTA;
			emit        = 1'b1;
			res_kind    = section_q;
			res_index   = run_idx_q;
			res_delta   = delta_q;
			bytes_d     = '0;
			remaining_d = remaining_q - 1'b1;
			if (remaining_q == VALUE_W'(1)) begin
				for (int i = 0; i < 4; i++) begin
					nonzero[i] = (counts_q[i] != '0);
				end
				next_list   = first_list(section_q, nonzero);
				section_d   = next_list;
				remaining_d = (next_list == KIND_HEADER) ? '0 :
				              counts_q[2'(next_list - 3'd1)];
				run_idx_d   = '0;
				res_last    = (next_list == KIND_HEADER);
			end
		end
	end

	// Advance decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			section_q   <= KIND_HEADER;
			slot_q      <= SLOT_DELTA;
			pos_q       <= '0;
			acc_q       <= '0;
			counts_q    <= '{default: '0};
			remaining_q <= '0;
			run_idx_q   <= '0;
			delta_q     <= '0;
			flags_q     <= '0;
			bytes_q     <= '0;
		end else if (advance) begin
			section_q   <= section_d;
			slot_q      <= slot_d;
			pos_q       <= pos_d;
			acc_q       <= acc_d;
			counts_q    <= counts_d;
			remaining_q <= remaining_d;
			run_idx_q   <= run_idx_d;
			delta_q     <= delta_d;
			flags_q     <= flags_d;
			bytes_q     <= bytes_d;
		end
	end

	// Result register valid: load on a finished header or record, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (advance && emit) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	// Result payload; counts only appear in header transactions
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			if (res_kind == KIND_HEADER) begin
				m_axis_tdata[4*VALUE_W-1:0] <= {counts_d[3], counts_d[2],
				                                counts_d[1], counts_d[0]};
			end else begin
				m_axis_tdata[4*VALUE_W-1:0] <= '0;
			end
			m_axis_tdata[TDATA_W-1:4*VALUE_W] <=
				(TDATA_W - 4*VALUE_W)'({bytes_inc, res_code, res_flags,
				                        res_delta, res_index});
			m_axis_tuser <= res_kind;
			m_axis_tlast <= res_last;
		end
	end

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the class-data ULEB128 decoder.
// Streams encoded class-data items into the block, predicts each header and member
// record in step with the input, and checks every result. Depends on cdu_pkg and the top.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cdu_pkg::*;

	localparam int HOLD_CYCLES = 300;

	// One decoded header or member record, as the block should report it
	typedef struct packed {
		logic [2:0]       kind;
		logic [3:0][31:0] counts;
		logic [31:0]      index;
		logic [31:0]      delta;
		logic [31:0]      flags;
		logic [31:0]      code;
		logic [4:0]       rbytes;
		logic             last;
	} record_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [TDATA_W-1:0]   m_axis_tdata;
	logic [KIND_W-1:0]    m_axis_tuser;
	logic                 m_axis_tlast;

	// Decoder state mirrored by the predictor
	logic [2:0]       dec_section;
	logic [1:0]       dec_slot;
	logic [2:0]       dec_pos;
	logic [31:0]      dec_acc;
	logic [3:0][31:0] dec_counts;
	logic [31:0]      dec_remaining;
	logic [31:0]      dec_index;
	logic [31:0]      dec_delta;
	logic [31:0]      dec_flags;
	logic [4:0]       dec_nbytes;

	record_t    pending_records[$];
	logic [7:0] item_bytes[$];
	record_t    got_record;
	record_t    want_record;
	int         mismatches;
	int         bytes_sent;
	int         results_seen[5];
	int         idle_pct;
	int         stall_pct;
	bit         hold_req;
	int         hold_cnt;

	class_data_uleb128_decoder_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	// Free-running clock, 4 ns period
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Move to the first nonempty list after 'from'; return 1 when the item is complete
	function automatic bit open_next_list(input logic [2:0] from);
		for (int s = from + 1; s <= 4; s++) begin
			if (dec_counts[s - 1] != 32'd0) begin
				dec_section   = 3'(s);
				dec_remaining = dec_counts[s - 1];
				dec_index     = 32'd0;
				return 1'b0;
			end
		end
		dec_section   = KIND_HEADER;
		dec_remaining = 32'd0;
		dec_index     = 32'd0;
		return 1'b1;
	endfunction

	// Advance the predicted decoder by one accepted byte; queue any record it completes
	function automatic void decode_byte(input logic [7:0] b);
		logic [2:0]  p;
		logic [31:0] value;
		logic [31:0] code;
		record_t     r;
		p = (dec_pos > POS_MAX) ? POS_MAX : dec_pos;
		dec_acc = dec_acc | ({25'd0, b[6:0]} << (7 * p));
		dec_nbytes = dec_nbytes + 5'd1;
		// continuation bit holds the value open, except on its fifth byte
		if (b[7] && p < POS_MAX) begin
			dec_pos = p + 3'd1;
			return;
		end
		value   = dec_acc;
		dec_acc = 32'd0;
		dec_pos = 3'd0;
		r       = '0;
		if (dec_section == KIND_HEADER || dec_section > KIND_VIRTUAL) begin
			dec_section = KIND_HEADER;
			dec_counts[dec_slot] = value;
			if (dec_slot != SLOT_LAST_COUNT) begin
				dec_slot = dec_slot + 2'd1;
				return;
			end
			dec_slot   = SLOT_DELTA;
			r.kind     = KIND_HEADER;
			r.counts   = dec_counts;
			r.rbytes   = dec_nbytes;
			r.last     = open_next_list(KIND_HEADER);
			dec_nbytes = 5'd0;
			pending_records.push_back(r);
			return;
		end
		if (dec_slot == SLOT_DELTA) begin
			dec_delta = value;
			dec_index = dec_index + value;
			dec_slot  = SLOT_FLAGS;
			return;
		end
		if (dec_slot == SLOT_FLAGS && dec_section >= KIND_DIRECT) begin
			dec_flags = value;
			dec_slot  = SLOT_CODE;
			return;
		end
		code = 32'd0;
		if (dec_slot == SLOT_FLAGS) begin
			dec_flags = value;
		end else begin
			code = value;
		end
		dec_slot      = SLOT_DELTA;
		r.kind        = dec_section;
		r.index       = dec_index;
		r.delta       = dec_delta;
		r.flags       = dec_flags;
		r.code        = code;
		r.rbytes      = dec_nbytes;
		dec_nbytes    = 5'd0;
		dec_remaining = dec_remaining - 32'd1;
		r.last        = (dec_remaining == 32'd0) ? open_next_list(r.kind) : 1'b0;
		pending_records.push_back(r);
	endfunction

	function automatic bit at_item_start();
		return dec_section == KIND_HEADER && dec_slot == SLOT_DELTA && dec_pos == 3'd0;
	endfunction

	// Mostly small magnitudes, with zero, full-width and all-ones values mixed in
	function automatic logic [31:0] rand_value();
		case ($urandom_range(9))
			0:       return 32'd0;
			1, 2, 3: return 32'($urandom_range(127));
			4, 5:    return 32'($urandom_range(16383));
			6:       return $urandom() >> $urandom_range(31);
			7:       return $urandom();
			8:       return 32'hFFFF_FFFF;
			default: return 32'($urandom_range(1, 3));
		endcase
	endfunction

	// Encode as ULEB128, sometimes padded out to more bytes than needed
	function automatic void append_value(input logic [31:0] v);
		int n;
		n = 1;
		while (n < 5 && (v >> (7 * n)) != 32'd0) n++;
		if ($urandom_range(7) == 0) n = $urandom_range(n, 5);
		for (int i = 0; i < n - 1; i++) begin
			item_bytes.push_back({1'b1, 7'(v >> (7 * i))});
		end
		if (n == 5) begin
			// fifth byte: top and spare bits are junk the decoder must drop
			item_bytes.push_back({1'($urandom_range(1)), 3'($urandom_range(7)), v[31:28]});
		end else begin
			item_bytes.push_back({1'b0, 7'(v >> (7 * (n - 1)))});
		end
	endfunction

	// Build one well-formed class-data item with small list counts
	function automatic void build_item();
		logic [3:0][31:0] cnt;
		item_bytes.delete();
		for (int k = 0; k < 4; k++) begin
			cnt[k] = ($urandom_range(2) == 0) ? 32'd0 : 32'($urandom_range(1, 4));
			append_value(cnt[k]);
		end
		for (int k = 0; k < 4; k++) begin
			for (int r = 0; r < cnt[k]; r++) begin
				append_value(rand_value());
				append_value(rand_value());
				if (k >= 2) append_value(rand_value());
			end
		end
	endfunction

	// Offer one byte, with optional idle cycles first; returns on the falling edge
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		decode_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_item_bytes();
		foreach (item_bytes[i]) send_byte(item_bytes[i]);
	endtask

	// Send a random item; a broken one is cut short and flushed with zero bytes
	task automatic send_random_item(input bit broken);
		int cut;
		build_item();
		if (broken) begin
			cut = $urandom_range(1, item_bytes.size() - 1);
			while (item_bytes.size() > cut) void'(item_bytes.pop_back());
		end
		send_item_bytes();
		while (!at_item_start()) send_byte(8'h00);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_records.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// All-zero header, empty lists, index wrap, fifth-byte truncation
	task automatic test_directed();
		idle_pct  = 0;
		stall_pct = 0;
		item_bytes = '{8'h80, 8'h80, 8'h80, 8'h80, 8'hF0, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h02, 8'h00, 8'h01,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00,
			8'h02, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h7F, 8'h01, 8'h80, 8'h80, 8'h80, 8'h80, 8'h8F};
		send_item_bytes();
		wait_drained();
	endtask

	// Mostly well-formed items, one in ten broken off part way
	task automatic test_random_mix(input int idle, input int stall, input int nbytes);
		int start;
		idle_pct  = idle;
		stall_pct = stall;
		start     = bytes_sent;
		while (bytes_sent - start < nbytes) send_random_item($urandom_range(9) == 0);
	endtask

	// Hold the result side off while input keeps coming, then pause until drained
	task automatic test_back_pressure();
		idle_pct  = 0;
		stall_pct = 0;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		hold_req = 1'b1;
		@(negedge clk);
		while (hold_req) send_random_item(1'b0);
		wait_drained();
		send_random_item(1'b0);
		wait_drained();
	endtask

	// Counts at the top of their range; the stream stays inside the first list
	task automatic test_huge_counts();
		idle_pct  = 25;
		stall_pct = 25;
		item_bytes.delete();
		append_value(32'hFFFF_FFFF);
		append_value(32'h8000_0000);
		append_value(32'd0);
		append_value(32'd1);
		for (int r = 0; r < 20; r++) begin
			append_value(rand_value());
			append_value(rand_value());
		end
		send_item_bytes();
	endtask

	// Result side: random stalls, or a counted hold-off when one is requested
	initial begin
		m_axis_tready = 1'b0;
		hold_cnt      = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				hold_cnt++;
				if (hold_cnt == HOLD_CYCLES) begin
					hold_req = 1'b0;
					hold_cnt = 0;
				end
			end else begin
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
					    input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%08h, got 0x%08h", name, want, got);
			mismatches++;
		end
	endfunction

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			if (pending_records.size() == 0) begin
				$error("result with nothing pending, kind %0d", m_axis_tuser);
				mismatches++;
			end else begin
				want_record = pending_records.pop_front();
				got_record  = '0;
				got_record.kind   = m_axis_tuser;
				got_record.counts = m_axis_tdata[127:0];
				got_record.index  = m_axis_tdata[128 +: 32];
				got_record.delta  = m_axis_tdata[160 +: 32];
				got_record.flags  = m_axis_tdata[192 +: 32];
				got_record.code   = m_axis_tdata[224 +: 32];
				got_record.rbytes = m_axis_tdata[256 +: BYTES_W];
				got_record.last   = m_axis_tlast;
				check_field("record_kind", 32'(want_record.kind), 32'(got_record.kind));
				check_field("static_count", want_record.counts[0], got_record.counts[0]);
				check_field("instance_count", want_record.counts[1], got_record.counts[1]);
				check_field("direct_count", want_record.counts[2], got_record.counts[2]);
				check_field("virtual_count", want_record.counts[3], got_record.counts[3]);
				check_field("member_index", want_record.index, got_record.index);
				check_field("index_delta", want_record.delta, got_record.delta);
				check_field("member_flags", want_record.flags, got_record.flags);
				check_field("code_offset", want_record.code, got_record.code);
				check_field("record_bytes", 32'(want_record.rbytes), 32'(got_record.rbytes));
				check_field("last", 32'(want_record.last), 32'(got_record.last));
				if (want_record.kind <= KIND_VIRTUAL) results_seen[want_record.kind]++;
			end
		end
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Test sequence
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		hold_req      = 1'b0;
		idle_pct      = 0;
		stall_pct     = 0;
		mismatches    = 0;
		bytes_sent    = 0;
		foreach (results_seen[i]) results_seen[i] = 0;
		dec_section   = KIND_HEADER;
		dec_slot      = SLOT_DELTA;
		dec_pos       = 3'd0;
		dec_acc       = 32'd0;
		dec_counts    = '0;
		dec_remaining = 32'd0;
		dec_index     = 32'd0;
		dec_delta     = 32'd0;
		dec_flags     = 32'd0;
		dec_nbytes    = 5'd0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_mix(0, 0, 350);
		test_random_mix(75, 0, 350);
		test_random_mix(0, 75, 350);
		test_random_mix(33, 33, 350);
		test_back_pressure();
		test_huge_counts();

		// drain, then allow the pipeline to settle
		s_axis_tvalid <= 1'b0;
		while (pending_records.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d bytes; checked headers %0d, static %0d, instance %0d,",
			bytes_sent, results_seen[0], results_seen[1], results_seen[2]);
		$display("direct %0d, virtual %0d", results_seen[3], results_seen[4]);
		$display("Covered padded and truncated ULEB values, empty lists, index wrap, broken items, stalls");
		if (mismatches == 0 && pending_records.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/cdu_pkg.sv
sv/class_data_uleb128_decoder_top.sv
tb/sv/tb_top.sv
